FILE: sv/mcw_pkg.sv
// Package for the multi-channel watchdog: codes, widths, the channel table
// entry and the flag group passed from the channel evaluator to the top level.
// No dependencies.
package mcw_pkg;

	localparam int CHANNELS_DEF = 16;
	localparam int MASK_W       = 16;
	localparam int TMO_W        = 32;
	localparam int TICK_W       = 64;
	localparam int TOTAL_W      = 32;

	localparam logic [1:0] FN_REG  = 2'd0;
	localparam logic [1:0] FN_FEED = 2'd1;
	localparam logic [1:0] FN_TICK = 2'd2;

	localparam logic [1:0] STAT_OK       = 2'd0;
	localparam logic [1:0] STAT_NO_SPACE = 2'd1;
	localparam logic [1:0] STAT_NO_CHAN  = 2'd2;

	localparam logic [1:0] ACT_REBOOT  = 2'd0;
	localparam logic [1:0] ACT_PANIC   = 2'd1;
	localparam logic [1:0] ACT_RECOVER = 2'd2;
	localparam logic [1:0] ACT_NOTIFY  = 2'd3;

	localparam logic [1:0] MISS_LIMIT = 2'd3;
	localparam logic [1:0] MISS_WARN  = 2'd1;

	typedef struct packed {
		logic [TMO_W-1:0]  timeout;
		logic [TICK_W-1:0] last_fed;
		logic [1:0]        misses;
		logic [1:0]        action;
		logic              armed;
	} chan_entry_t;

	typedef struct packed {
		logic hl_we;
		logic hl_val;
		logic warn;
		logic fired;
		logic reboot;
		logic panic;
		logic recover;
	} eval_flags_t;

endpackage

FILE: sv/mcw_if.sv
// Valid/ready channel interfaces for the watchdog command and result streams.
// Depends on mcw_pkg for the field widths.
interface mcw_cmd_if import mcw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        func;
	logic [3:0]        channel;
	logic [TMO_W-1:0]  timeout;
	logic [1:0]        action;

	modport source (output valid, func, channel, timeout, action, input ready);
	modport sink   (input valid, func, channel, timeout, action, output ready);
endinterface

interface mcw_res_if import mcw_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [3:0]         assigned_channel;
	logic [MASK_W-1:0]  warn_mask;
	logic [MASK_W-1:0]  fired_mask;
	logic               reboot_request;
	logic               panic_request;
	logic [MASK_W-1:0]  unhealthy_mask;
	logic [TOTAL_W-1:0] reset_total;
	logic [TOTAL_W-1:0] recovery_total;

	modport source (output valid, status, assigned_channel, warn_mask, fired_mask,
		reboot_request, panic_request, unhealthy_mask, reset_total, recovery_total,
		input ready);
	modport sink   (input valid, status, assigned_channel, warn_mask, fired_mask,
		reboot_request, panic_request, unhealthy_mask, reset_total, recovery_total,
		output ready);
endinterface

FILE: sv/mcw_eval.sv
// Shared channel evaluator: one feed-age subtract and timeout compare, and the
// miss and action update of a single table entry. Depends on mcw_pkg.
module mcw_eval import mcw_pkg::*; (
	input  chan_entry_t       ent,
	input  logic [TICK_W-1:0] tick,
	input  logic              feed,
	output chan_entry_t       ent_out,
	output eval_flags_t       flags
);

	logic [TICK_W-1:0] age;
	logic              late;

	assign age  = tick - ent.last_fed;
	assign late = age > TICK_W'(ent.timeout);

	always_comb begin
		logic [1:0] m;
		m       = ent.misses;
		ent_out = ent;
		flags   = '0;
		if (feed) begin
			ent_out.misses   = 2'd0;
			ent_out.last_fed = tick;
			flags.hl_we      = 1'b1;
			flags.hl_val     = 1'b1;
		end else if (ent.armed && late) begin
			if (m < MISS_LIMIT) begin
				m = m + 2'd1;
			end
			flags.hl_we  = 1'b1;
			flags.hl_val = 1'b0;
			flags.warn   = (m == MISS_WARN);
			if (m == MISS_LIMIT) begin
				flags.fired = 1'b1;
				unique case (ent.action)
					ACT_RECOVER: begin
						m                = 2'd0;
						ent_out.last_fed = tick;
						flags.hl_val     = 1'b1;
						flags.recover    = 1'b1;
					end
					ACT_REBOOT: begin
						ent_out.armed = 1'b0;
						flags.reboot  = 1'b1;
					end
					ACT_PANIC: begin
						ent_out.armed = 1'b0;
						flags.panic   = 1'b1;
					end
					default: begin
						ent_out.armed = 1'b0;
					end
				endcase
			end
			ent_out.misses = m;
		end
	end

endmodule

FILE: sv/multi_channel_watchdog.sv
// Multi-channel watchdog: channel table in a single-port memory, swept by one
// shared evaluator. A register, rejected or unused-code item goes from idle straight
// to the finish state; a feed passes through one memory read and one evaluate/write state,
// a tick through both once per registered channel, before the result register loads. A new item is taken
// once the previous one has finished and the result register is free or draining.
// Asynchronous reset clears the tick, slot count and totals; the table is not cleared.
module multi_channel_watchdog import mcw_pkg::*; #(
	parameter int CHANNELS = CHANNELS_DEF
) (
	input logic   clk,
	input logic   arst_n,
	mcw_cmd_if.sink   cmd,
	mcw_res_if.source res
);

	localparam int SLOT_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int CNT_W  = $clog2(CHANNELS + 1);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_READ  = 2'd1;
	localparam logic [1:0] S_CHECK = 2'd2;
	localparam logic [1:0] S_FIN   = 2'd3;

	logic [1:0]         st_q;
	logic [TICK_W-1:0]  tick_q;
	logic [CNT_W-1:0]   used_q;
	logic [SLOT_W-1:0]  idx_q;
	logic               is_tick_q;
	logic [TOTAL_W-1:0] resets_q;
	logic [TOTAL_W-1:0] recov_q;
	logic [1:0]         stat_q;
	logic [3:0]         asg_q;
	logic [MASK_W-1:0]  warn_q;
	logic [MASK_W-1:0]  fired_q;
	logic               reboot_q;
	logic               panic_q;
	logic [CHANNELS-1:0] healthy_q;
	chan_entry_t        chan_mem_q [CHANNELS];
	chan_entry_t        rd_q;

	logic               res_valid_q;
	logic [1:0]         o_stat_q;
	logic [3:0]         o_asg_q;
	logic [MASK_W-1:0]  o_warn_q;
	logic [MASK_W-1:0]  o_fired_q;
	logic               o_reboot_q;
	logic               o_panic_q;
	logic [MASK_W-1:0]  o_unh_q;
	logic [TOTAL_W-1:0] o_resets_q;
	logic [TOTAL_W-1:0] o_recov_q;

	logic               accept;
	logic               has_space;
	logic               feed_ok;
	logic               last_slot;
	logic [MASK_W-1:0]  bit_sel;
	logic [MASK_W-1:0]  unh_mask;
	chan_entry_t        ent_out;
	chan_entry_t        new_ent;
	eval_flags_t        flags;
	logic               mem_we;
	logic [SLOT_W-1:0]  mem_wa;
	chan_entry_t        mem_wd;

	assign cmd.ready = (st_q == S_IDLE) && (!res_valid_q || res.ready);
	assign accept    = cmd.valid && cmd.ready;
	assign has_space = int'(used_q) < CHANNELS;
	assign feed_ok   = int'(cmd.channel) < int'(used_q);
	assign last_slot = (CNT_W'(idx_q) + CNT_W'(1)) == used_q;
	assign bit_sel   = MASK_W'(1) << idx_q;

	mcw_eval u_eval (
		.ent     (rd_q),
		.tick    (tick_q),
		.feed    (!is_tick_q),
		.ent_out (ent_out),
		.flags   (flags)
	);

	always_comb begin
		new_ent.timeout  = cmd.timeout;
		new_ent.last_fed = tick_q;
		new_ent.misses   = 2'd0;
		new_ent.action   = cmd.action;
		new_ent.armed    = 1'b1;
		mem_we = (st_q == S_CHECK) || (accept && cmd.func == FN_REG && has_space);
		mem_wa = (st_q == S_CHECK) ? idx_q : SLOT_W'(used_q);
		mem_wd = (st_q == S_CHECK) ? ent_out : new_ent;
	end

	// Only registered slots below the fill count report as unhealthy.
	for (genvar b = 0; b < MASK_W; b++) begin : g_unh
		if (b < CHANNELS) begin : g_on
			assign unh_mask[b] = (b < int'(used_q)) && !healthy_q[b];
		end else begin : g_off
			assign unh_mask[b] = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			chan_mem_q[mem_wa] <= mem_wd;
		end
		if (st_q == S_READ) begin
			rd_q <= chan_mem_q[idx_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && cmd.func == FN_REG && has_space) begin
			healthy_q[SLOT_W'(used_q)] <= 1'b1;
		end else if (st_q == S_CHECK && flags.hl_we) begin
			healthy_q[idx_q] <= flags.hl_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			tick_q    <= '0;
			used_q    <= '0;
			resets_q  <= '0;
			recov_q   <= '0;
			idx_q     <= '0;
			is_tick_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						is_tick_q <= (cmd.func == FN_TICK);
						if (cmd.func == FN_FEED && feed_ok) begin
							idx_q <= SLOT_W'(cmd.channel);
							st_q  <= S_READ;
						end else begin
							idx_q <= '0;
							if (cmd.func == FN_TICK && used_q != '0) begin
								st_q <= S_READ;
							end else begin
								st_q <= S_FIN;
							end
						end
						if (cmd.func == FN_REG && has_space) begin
							used_q <= used_q + CNT_W'(1);
						end
						if (cmd.func == FN_TICK) begin
							tick_q <= tick_q + TICK_W'(1);
						end
					end
				end
				S_READ: begin
					st_q <= S_CHECK;
				end
				S_CHECK: begin
					if (is_tick_q) begin
						if (flags.reboot && resets_q != '1) begin
							resets_q <= resets_q + TOTAL_W'(1);
						end
						if (flags.recover && recov_q != '1) begin
							recov_q <= recov_q + TOTAL_W'(1);
						end
					end
					if (!is_tick_q || last_slot) begin
						st_q <= S_FIN;
					end else begin
						idx_q <= idx_q + SLOT_W'(1);
						st_q  <= S_READ;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	// Per-item result fields, collected while the item is worked on.
	always_ff @(posedge clk) begin
		if (accept) begin
			warn_q   <= '0;
			fired_q  <= '0;
			reboot_q <= 1'b0;
			panic_q  <= 1'b0;
			if (cmd.func == FN_REG && has_space) begin
				asg_q <= 4'(used_q);
			end else begin
				asg_q <= '0;
			end
			if (cmd.func == FN_REG && !has_space) begin
				stat_q <= STAT_NO_SPACE;
			end else if (cmd.func == FN_FEED && !feed_ok) begin
				stat_q <= STAT_NO_CHAN;
			end else begin
				stat_q <= STAT_OK;
			end
		end else if (st_q == S_CHECK && is_tick_q) begin
			if (flags.warn) begin
				warn_q <= warn_q | bit_sel;
			end
			if (flags.fired) begin
				fired_q <= fired_q | bit_sel;
			end
			reboot_q <= reboot_q | flags.reboot;
			panic_q  <= panic_q | flags.panic;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (st_q == S_FIN) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_FIN) begin
			o_stat_q   <= stat_q;
			o_asg_q    <= asg_q;
			o_warn_q   <= warn_q;
			o_fired_q  <= fired_q;
			o_reboot_q <= reboot_q;
			o_panic_q  <= panic_q;
			o_unh_q    <= unh_mask;
			o_resets_q <= resets_q;
			o_recov_q  <= recov_q;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.status           = o_stat_q;
	assign res.assigned_channel = o_asg_q;
	assign res.warn_mask        = o_warn_q;
	assign res.fired_mask       = o_fired_q;
	assign res.reboot_request   = o_reboot_q;
	assign res.panic_request    = o_panic_q;
	assign res.unhealthy_mask   = o_unh_q;
	assign res.reset_total      = o_resets_q;
	assign res.recovery_total   = o_recov_q;

`ifndef SYNTHESIS
	a_used_bound: assert property (@(posedge clk) disable iff (!arst_n)
		int'(used_q) <= CHANNELS)
		else $error("slot count exceeds the table size");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> (st_q == S_IDLE))
		else $error("command ready while an item is in progress");

	a_fin_loads: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN) |=> res_valid_q)
		else $error("finished item produced no result");

	a_fin_free: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_FIN) |-> !res_valid_q)
		else $error("result register overwritten before transfer");

	a_reg_grow: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && cmd.func == FN_REG && has_space) |=> used_q == $past(used_q) + CNT_W'(1))
		else $error("register did not take a slot");
`endif

endmodule
